// ===== rtl/pba_pkg.sv =====
// Package for the power-of-two bin allocator: beat structs, status codes,
// sequencer states. No dependencies.
`timescale 1ns / 1ps
package pba_pkg;

  localparam int CLASS_W = 4;
  localparam logic [CLASS_W-1:0] NO_CLASS = 4'd15;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_TOO_LARGE = 2'd1;
  localparam logic [1:0] ST_NO_MEMORY = 2'd2;
  localparam logic [1:0] ST_BAD_FREE  = 2'd3;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [15:0] request_bytes;
    logic [15:0] free_offset;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] payload_offset;
  } out_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_TAKE,
    S_SPLIT,
    S_FREE_RD,
    S_FREE_CHK,
    S_DONE
  } state_t;

endpackage

// ===== rtl/power_of_two_bin_allocator.sv =====
// Top level of the power-of-two bin allocator: sequencer, scan and split
// datapath. Depends on pba_pkg and pba_ram.
//
//  channel | ports                     | handshake
//  --------+---------------------------+------------------------------
//  input   | start, busy, in_item      | beat taken when start & !busy
//  result  | out_valid, out_item       | one-cycle strobe, no stall
//
// A free reads the granule entry, then checks it and marks the chunk free; a request
// rejected at decode (too large, malformed free offset) goes straight to the result without
// touching the store. An allocate scans the granule store one entry a cycle from the bottom
// until a chunk of the chosen class turns up or the last entry is read, keeping the first
// entry of the lowest class found, then writes the taken chunk and one upper half per class
// split. The store's single read port sets the scan rate. After reset a clearing pass
// writes every entry and loads the initial chunks while busy stays high.
`timescale 1ns / 1ps
module power_of_two_bin_allocator
  import pba_pkg::*;
#(
  parameter int REGION_BYTES    = 65536,
  parameter int MIN_CHUNK_BYTES = 32,
  parameter int NUM_CLASSES     = 11,
  parameter int HEADER_BYTES    = 24
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_item,
  output logic out_valid,
  output out_t out_item
);

  localparam int GRANULES  = REGION_BYTES / MIN_CHUNK_BYTES;
  localparam int AW        = $clog2(GRANULES);
  localparam int TOP_GR    = 1 << (NUM_CLASSES - 1);
  localparam int TOP_BYTES = MIN_CHUNK_BYTES << (NUM_CLASSES - 1);
  localparam int EW        = NUM_CLASSES + CLASS_W + 1;
  localparam logic [AW-1:0] LAST_G = AW'(GRANULES - 1);

  // entry layout: free map | class | in use
  function automatic logic [EW-1:0] mk_entry(logic [NUM_CLASSES-1:0] fmap,
                                             logic [CLASS_W-1:0] cls, logic used);
    return {fmap, cls, used};
  endfunction

  state_t state_r, state_nxt;

  logic [AW-1:0]      clr_addr_r, clr_addr_nxt;
  logic [AW-1:0]      scan_addr_r, scan_addr_nxt;
  logic               iss_done_r, iss_done_nxt;
  logic               rd_vld_r, rd_vld_nxt;
  logic [AW-1:0]      rd_g_r, rd_g_nxt;
  logic [CLASS_W-1:0] best_k_r, best_k_nxt;
  logic [AW-1:0]      best_g_r, best_g_nxt;
  logic [CLASS_W-1:0] cls_r, cls_nxt;
  logic [CLASS_W-1:0] k_r, k_nxt;
  logic [1:0]         status_r, status_nxt;
  logic [15:0]        offset_r, offset_nxt;

  logic               wr_en, rd_en;
  logic [AW-1:0]      wr_addr, rd_addr;
  logic [EW-1:0]      wr_data, rd_data;

  pba_ram #(.WIDTH(EW), .DEPTH(GRANULES)) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  logic [NUM_CLASSES-1:0] rd_map;
  logic [CLASS_W-1:0]     rd_cls;
  logic                   rd_used;
  assign rd_map  = rd_data[EW-1 -: NUM_CLASSES];
  assign rd_cls  = rd_data[CLASS_W:1];
  assign rd_used = rd_data[0];

  // request decode
  logic [16:0]        need;
  logic               too_large;
  logic [CLASS_W-1:0] pick;
  logic [16:0]        chunk_off;
  logic               free_bad;
  logic [AW-1:0]      free_g;

  always_comb begin
    need      = {1'b0, in_item.request_bytes} + 17'(HEADER_BYTES);
    too_large = 32'(need) > 32'(TOP_BYTES);
    pick      = CLASS_W'(NUM_CLASSES - 1);
    for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
      if (32'(MIN_CHUNK_BYTES << i) >= 32'(need)) begin
        pick = CLASS_W'(i);
      end
    end
    chunk_off = {1'b0, in_item.free_offset} - 17'(HEADER_BYTES);
    free_bad  = (32'(in_item.free_offset) < 32'(HEADER_BYTES)) ||
                (32'(chunk_off) % MIN_CHUNK_BYTES != 0) ||
                (32'(chunk_off) / MIN_CHUNK_BYTES >= GRANULES);
    free_g    = AW'(32'(chunk_off) / MIN_CHUNK_BYTES);
  end

  // scan evaluation: lowest class at or above the chosen one in this entry
  logic               ent_has;
  logic [CLASS_W-1:0] ent_k;
  logic               upd;
  logic [CLASS_W-1:0] found_k;
  logic [AW-1:0]      found_g;
  logic               scan_end;

  always_comb begin
    ent_has = 1'b0;
    ent_k   = NO_CLASS;
    for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
      if (rd_map[i] && (CLASS_W'(i) >= cls_r)) begin
        ent_has = 1'b1;
        ent_k   = CLASS_W'(i);
      end
    end
    upd      = rd_vld_r && ent_has && (ent_k < best_k_r);
    found_k  = upd ? ent_k : best_k_r;
    found_g  = upd ? rd_g_r : best_g_r;
    scan_end = rd_vld_r && ((found_k == cls_r) || (rd_g_r == LAST_G));
  end

  logic [CLASS_W-1:0] k_dn;
  logic [AW-1:0]      upper_g;
  assign k_dn    = k_r - CLASS_W'(1);
  assign upper_g = best_g_r + (AW'(1) << k_dn);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR:    if (clr_addr_r == LAST_G) state_nxt = S_IDLE;
      S_IDLE: begin
        if (start) begin
          if (in_item.operation == OP_ALLOC) begin
            state_nxt = too_large ? S_DONE : S_SCAN;
          end else begin
            state_nxt = free_bad ? S_DONE : S_FREE_RD;
          end
        end
      end
      S_SCAN:     if (scan_end) state_nxt = (found_k == NO_CLASS) ? S_DONE : S_TAKE;
      S_TAKE:     state_nxt = S_SPLIT;
      S_SPLIT:    if (k_r == cls_r) state_nxt = S_DONE;
      S_FREE_RD:  state_nxt = S_FREE_CHK;
      S_FREE_CHK: state_nxt = S_DONE;
      S_DONE:     state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // datapath and store control
  always_comb begin
    clr_addr_nxt  = clr_addr_r;
    scan_addr_nxt = scan_addr_r;
    iss_done_nxt  = iss_done_r;
    rd_vld_nxt    = 1'b0;
    rd_g_nxt      = scan_addr_r;
    best_k_nxt    = best_k_r;
    best_g_nxt    = best_g_r;
    cls_nxt       = cls_r;
    k_nxt         = k_r;
    status_nxt    = status_r;
    offset_nxt    = offset_r;
    wr_en         = 1'b0;
    wr_addr       = clr_addr_r;
    wr_data       = '0;
    rd_en         = 1'b0;
    rd_addr       = scan_addr_r;
    unique case (state_r)
      S_CLEAR: begin
        wr_en = 1'b1;
        if ((32'(clr_addr_r) % TOP_GR == 0) && (32'(clr_addr_r) + TOP_GR <= GRANULES)) begin
          wr_data = mk_entry(NUM_CLASSES'(1) << (NUM_CLASSES - 1),
                             CLASS_W'(NUM_CLASSES - 1), 1'b0);
        end else begin
          wr_data = mk_entry('0, NO_CLASS, 1'b0);
        end
        clr_addr_nxt = clr_addr_r + AW'(1);
      end
      S_IDLE: begin
        status_nxt    = ST_OK;
        offset_nxt    = '0;
        cls_nxt       = pick;
        best_k_nxt    = NO_CLASS;
        scan_addr_nxt = '0;
        iss_done_nxt  = 1'b0;
        best_g_nxt    = free_g;
        if (start) begin
          if (in_item.operation == OP_ALLOC) begin
            if (too_large) status_nxt = ST_TOO_LARGE;
          end else if (free_bad) begin
            status_nxt = ST_BAD_FREE;
          end
        end
      end
      S_SCAN: begin
        rd_en      = !iss_done_r && !scan_end;
        rd_vld_nxt = rd_en;
        if (rd_en) begin
          scan_addr_nxt = scan_addr_r + AW'(1);
          if (scan_addr_r == LAST_G) iss_done_nxt = 1'b1;
        end
        best_k_nxt = found_k;
        best_g_nxt = found_g;
        if (scan_end && (found_k == NO_CLASS)) status_nxt = ST_NO_MEMORY;
      end
      S_TAKE: begin
        wr_en      = 1'b1;
        wr_addr    = best_g_r;
        wr_data    = mk_entry('0, cls_r, 1'b1);
        k_nxt      = best_k_r;
        offset_nxt = 16'(32'(best_g_r) * MIN_CHUNK_BYTES + HEADER_BYTES);
      end
      S_SPLIT: begin
        // hand the upper half of the current chunk to the class below
        if (k_r != cls_r) begin
          wr_en   = 1'b1;
          wr_addr = upper_g;
          wr_data = mk_entry(NUM_CLASSES'(1) << k_dn, k_dn, 1'b0);
          k_nxt   = k_dn;
        end
      end
      S_FREE_RD: begin
        rd_en   = 1'b1;
        rd_addr = best_g_r;
      end
      S_FREE_CHK: begin
        if (rd_used && (32'(rd_cls) < NUM_CLASSES)) begin
          wr_en   = 1'b1;
          wr_addr = best_g_r;
          wr_data = mk_entry(NUM_CLASSES'(1) << rd_cls, rd_cls, 1'b0);
        end else begin
          status_nxt = ST_BAD_FREE;
        end
      end
      S_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      clr_addr_r <= '0;
      rd_vld_r   <= 1'b0;
      iss_done_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      rd_vld_r   <= rd_vld_nxt;
      iss_done_r <= iss_done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_addr_r <= scan_addr_nxt;
    rd_g_r      <= rd_g_nxt;
    best_k_r    <= best_k_nxt;
    best_g_r    <= best_g_nxt;
    cls_r       <= cls_nxt;
    k_r         <= k_nxt;
    status_r    <= status_nxt;
    offset_r    <= offset_nxt;
  end

  // outputs
  always_comb begin
    busy                    = (state_r != S_IDLE);
    out_valid               = (state_r == S_DONE);
    out_item.status         = status_r;
    out_item.payload_offset = (status_r == ST_OK) ? offset_r : 16'd0;
  end

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe held over two cycles");
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accepted beat did not raise busy");
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status != ST_OK) |-> out_item.payload_offset == 16'd0)
    else $error("nonzero offset on failed request");

endmodule

// ===== rtl/pba_ram.sv =====
// Single-port-write, single-port-read granule store with registered read.
// Depends on nothing.
`timescale 1ns / 1ps
module pba_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== tb/sv/power_of_two_bin_allocator_tb.sv =====
// Self-checking bench for the power-of-two bin allocator: a behavioral allocator
// predicts every result beat. Depends on pba_pkg and the allocator RTL.
`timescale 1ns / 1ps
module power_of_two_bin_allocator_tb;
  import pba_pkg::*;

  localparam int GRANULES  = 2048;
  localparam int TOP_CLS   = 10;
  localparam int TOP_BYTES = 32768;
  localparam int HDR       = 24;
  localparam int WDOG_MAX  = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t  in_item = '0;
  logic out_valid;
  out_t out_item;

  power_of_two_bin_allocator u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_item(out_item)
  );

  always #5 clk = ~clk;

  logic [10:0] free_map [GRANULES];
  logic [3:0]  cls_tab  [GRANULES];
  logic        in_use   [GRANULES];
  out_t        expected_q[$];
  logic [15:0] live_q[$];
  int errors = 0, n_items = 0, n_ok = 0, n_full = 0, n_big = 0, n_bad = 0, idle_cyc = 0;

  task automatic allocator_reset();
    for (int g = 0; g < GRANULES; g++) begin
      free_map[g] = '0; cls_tab[g] = NO_CLASS; in_use[g] = 1'b0;
    end
    free_map[0][TOP_CLS] = 1'b1; free_map[1024][TOP_CLS] = 1'b1;
    cls_tab[0] = TOP_CLS; cls_tab[1024] = TOP_CLS;
  endtask

  function automatic out_t allocate_result(input logic [15:0] req);
    out_t r;
    int need, c, k, g;
    r = '0; g = -1;
    need = int'(req) + HDR;
    if (need > TOP_BYTES) begin
      r.status = ST_TOO_LARGE; return r;
    end
    c = 0;
    while (c < TOP_CLS && (32 << c) < need) c++;
    for (k = c; k <= TOP_CLS && g < 0; k++)
      for (int i = 0; i < GRANULES; i++)
        if (free_map[i][k]) begin
          g = i; break;
        end
    if (g < 0) begin
      r.status = ST_NO_MEMORY; return r;
    end
    k--;
    free_map[g][k] = 1'b0;
    while (k > c) begin
      k--;
      free_map[g + (1 << k)][k] = 1'b1;
      cls_tab[g + (1 << k)] = k[3:0];
      in_use[g + (1 << k)] = 1'b0;
    end
    cls_tab[g] = c[3:0]; in_use[g] = 1'b1;
    r.status = ST_OK;
    r.payload_offset = 16'(g * 32 + HDR);
    live_q.push_back(r.payload_offset);
    return r;
  endfunction

  function automatic out_t free_result(input logic [15:0] off);
    out_t r;
    int chunk, g;
    r = '0; r.status = ST_BAD_FREE;
    if (off < HDR) return r;
    chunk = int'(off) - HDR;
    if (chunk % 32 != 0) return r;
    g = chunk / 32;
    if (!in_use[g] || cls_tab[g] > TOP_CLS) return r;
    in_use[g] = 1'b0;
    free_map[g][cls_tab[g]] = 1'b1;
    r.status = ST_OK;
    return r;
  endfunction

  task automatic random_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) :
        ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 3));
    repeat (n) @(negedge clk);
  endtask

  // Drive one beat; the model is updated when the beat is taken.
  task automatic send_request(input logic op, input logic [15:0] req, input logic [15:0] off,
                              input bit gaps = 1);
    if (gaps) random_gap();
    in_item.operation = op; in_item.request_bytes = req; in_item.free_offset = off;
    start = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_q.push_back(op == OP_ALLOC ? allocate_result(req) : free_result(off));
    n_items++;
    @(negedge clk);
    start = 1'b0;
  endtask

  always @(posedge clk) begin
    if (start && !busy) idle_cyc <= 0;
    else idle_cyc <= idle_cyc + 1;
    if (rst_n && out_valid) begin
      if (expected_q.size() == 0) begin
        $display("%0t: result with none expected: %h", $time, out_item);
        errors++;
      end else begin
        out_t e;
        e = expected_q.pop_front();
        case (e.status)
          ST_OK: n_ok++;
          ST_NO_MEMORY: n_full++;
          ST_TOO_LARGE: n_big++;
          default: n_bad++;
        endcase
        if (e.status !== out_item.status) begin
          $display("%0t: status expected %0d actual %0d", $time, e.status, out_item.status);
          errors++;
        end
        if (e.payload_offset !== out_item.payload_offset) begin
          $display("%0t: offset expected %h actual %h", $time, e.payload_offset,
                   out_item.payload_offset);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (idle_cyc > WDOG_MAX) begin
      $display("%0t: watchdog, no beat accepted", $time);
      $display("power_of_two_bin_allocator regression: fail");
      $finish;
    end
  end

  function automatic logic [15:0] pick_live();
    int i;
    logic [15:0] v;
    i = $urandom_range(0, live_q.size() - 1);
    v = live_q[i];
    live_q.delete(i);
    return v;
  endfunction

  task automatic test_extremes();
    send_request(OP_ALLOC, 16'd0, 16'hffff);
    send_request(OP_ALLOC, 16'd8, 16'h0);
    send_request(OP_ALLOC, 16'd9, 16'h0);
    send_request(OP_ALLOC, 16'(TOP_BYTES - HDR), 16'h0);
    send_request(OP_ALLOC, 16'(TOP_BYTES - HDR + 1), 16'h0);
    send_request(OP_ALLOC, 16'hffff, 16'h0);
    send_request(OP_ALLOC, 16'd1000, 16'h0);
  endtask

  task automatic test_bad_frees();
    send_request(OP_FREE, 16'h0, 16'd0);
    send_request(OP_FREE, 16'h0, 16'd23);
    send_request(OP_FREE, 16'h0, 16'd25);
    send_request(OP_FREE, 16'hffff, 16'hffff);
    send_request(OP_FREE, 16'h0, 16'hfff8);
    send_request(OP_FREE, 16'h0, 16'd56);
    // free one live chunk, then the same one again
    begin
      logic [15:0] o;
      o = pick_live();
      send_request(OP_FREE, 16'h0, o);
      send_request(OP_FREE, 16'h0, o);
    end
  endtask

  task automatic test_exhaustion();
    send_request(OP_ALLOC, 16'(TOP_BYTES - HDR), 16'h0);
    send_request(OP_ALLOC, 16'(TOP_BYTES - HDR), 16'h0);
    while (live_q.size() > 0) send_request(OP_FREE, 16'h0, pick_live());
  endtask

  task automatic test_random_mix();
    for (int i = 0; i < 1000; i++) begin
      int sel;
      logic [15:0] req;
      sel = $urandom_range(0, 99);
      req = (sel < 5) ? 16'($urandom) : 16'($urandom_range(0, 1 << $urandom_range(3, 12)));
      if (sel < 50 || live_q.size() == 0)
        send_request(OP_ALLOC, req, 16'($urandom), i % 50 != 0);
      else if (sel < 92)
        send_request(OP_FREE, 16'($urandom), pick_live(), i % 50 != 0);
      else
        send_request(OP_FREE, req, 16'($urandom));
    end
  endtask

  initial begin
    allocator_reset();
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    test_extremes();
    test_bad_frees();
    test_exhaustion();
    test_random_mix();
    while (expected_q.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Beats sent: %0d; ok %0d, out of memory %0d, too large %0d, bad free %0d.",
             n_items, n_ok, n_full, n_big, n_bad);
    if (errors == 0) $display("power_of_two_bin_allocator regression: pass");
    else $display("power_of_two_bin_allocator regression: fail");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/pba_pkg.sv
rtl/pba_ram.sv
rtl/power_of_two_bin_allocator.sv
tb/sv/power_of_two_bin_allocator_tb.sv
